[sv/barc_pkg.sv]
// Shared types and constants for the adaptive ray count controller.
// Holds the controller states, command and status structs and register indexes.
// No dependencies.
package barc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int FRAC_W     = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_RAY_LIMIT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_BUDGET  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAY_FLOOR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVER_FRAC = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVER_CAP  = 3'd4;

    localparam logic [FRAC_W-1:0] FRAC_ONE      = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_RST      = 17'd6554;
    localparam int                RAY_LIMIT_RST = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_DBL,
        ST_DIV_ADD,
        ST_DIV_DONE,
        ST_STEP,
        ST_RECOVER,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic div_start;
        logic div_dbl;
        logic div_add;
        logic div_commit;
        logic mul;
        logic step;
        logic recover_commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic disabled;
        logic zero_budget;
        logic started;
        logic over;
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

[sv/barc_ctrl.sv]
// Controller state machine of the adaptive ray count controller.
// Sequences capture, the bit-serial scaling division, recovery and output load.
// Depends on barc_pkg.
module barc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  barc_pkg::status_t status,
    output barc_pkg::cmd_t    cmd
);

    barc_pkg::state_t state_reg;
    barc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= barc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            barc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = barc_pkg::ST_EVAL;
                end
            end
            barc_pkg::ST_EVAL:
            begin
                priority if (status.disabled || status.zero_budget)
                begin
                    state_next = barc_pkg::ST_FINISH;
                end
                else if (!status.started)
                begin
                    cmd.init   = 1'b1;
                    state_next = barc_pkg::ST_FINISH;
                end
                else if (status.over)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = barc_pkg::ST_DIV_DBL;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = barc_pkg::ST_STEP;
                end
            end
            barc_pkg::ST_DIV_DBL:
            begin
                cmd.div_dbl = 1'b1;
                state_next  = barc_pkg::ST_DIV_ADD;
            end
            barc_pkg::ST_DIV_ADD:
            begin
                cmd.div_add = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = barc_pkg::ST_DIV_DONE;
                end
                else
                begin
                    state_next = barc_pkg::ST_DIV_DBL;
                end
            end
            barc_pkg::ST_DIV_DONE:
            begin
                cmd.div_commit = 1'b1;
                state_next     = barc_pkg::ST_FINISH;
            end
            barc_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = barc_pkg::ST_RECOVER;
            end
            barc_pkg::ST_RECOVER:
            begin
                cmd.recover_commit = 1'b1;
                state_next         = barc_pkg::ST_FINISH;
            end
            barc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = barc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = barc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/barc_datapath.sv]
// Datapath of the adaptive ray count controller: configuration registers,
// adaptive target, bit-serial scaling divider, recovery step and output register.
// Depends on barc_pkg.
module barc_datapath
#(
    parameter int RAY_BITS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [barc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [((RAY_BITS > TIME_BITS) ? RAY_BITS :
                   ((TIME_BITS > barc_pkg::FRAC_W) ? TIME_BITS :
                    barc_pkg::FRAC_W))-1:0]      cfg_data,
    input  logic                                 in_active,
    input  logic                                 in_run,
    input  logic [TIME_BITS-1:0]                 in_last,
    input  barc_pkg::cmd_t                       cmd,
    output barc_pkg::status_t                    status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [RAY_BITS-1:0]                  out_eff,
    output logic [RAY_BITS-1:0]                  out_tgt
);

    localparam int CNT_W  = $clog2(RAY_BITS);
    localparam int PROD_W = RAY_BITS + barc_pkg::FRAC_W;
    localparam int RND_W  = PROD_W + 1;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(RAY_BITS - 1);
    localparam logic [RND_W-1:0] RND_ADD = RND_W'(65535);

    logic [RAY_BITS-1:0]           ray_limit_reg;
    logic [TIME_BITS-1:0]          budget_reg;
    logic [RAY_BITS-1:0]           ray_floor_reg;
    logic [barc_pkg::FRAC_W-1:0]   frac_reg;
    logic [RAY_BITS-1:0]           cap_reg;
    logic [RAY_BITS-1:0]           adapt_reg;
    logic [RAY_BITS-1:0]           adapt_next;
    logic                          started_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic                          act_reg;
    logic                          run_reg;
    logic [TIME_BITS-1:0]          last_reg;
    logic [TIME_BITS-1:0]          rem_reg;
    logic [TIME_BITS-1:0]          rem_next;
    logic [RAY_BITS-1:0]           quo_reg;
    logic [RAY_BITS-1:0]           quo_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [PROD_W-1:0]             prod_reg;
    logic [RAY_BITS-1:0]           step_reg;
    logic [RAY_BITS-1:0]           step_next;
    logic [RAY_BITS-1:0]           out_eff_reg;
    logic [RAY_BITS-1:0]           out_eff_next;
    logic [RAY_BITS-1:0]           out_tgt_reg;
    logic [RAY_BITS-1:0]           out_tgt_next;

    logic [RAY_BITS-1:0]           min_rays;
    logic [RAY_BITS-1:0]           eff_rays;
    logic [RAY_BITS-1:0]           clip_lo;
    logic [barc_pkg::FRAC_W-1:0]   frac_sat;
    logic [TIME_BITS:0]            dbl;
    logic [TIME_BITS:0]            add_sum;
    logic                          dbl_wrap;
    logic                          add_wrap;
    logic [RND_W-1:0]              rounded;
    logic [RAY_BITS-1:0]           step_raw;
    logic [RAY_BITS:0]             rec_sum;
    logic                          disabled;
    logic                          zero_budget;

    // derived floor and clamped output
    always_comb
    begin
        min_rays = (ray_floor_reg < ray_limit_reg) ? ray_floor_reg : ray_limit_reg;
        if (min_rays == '0)
        begin
            min_rays = RAY_BITS'(1);
        end
        eff_rays = (adapt_reg < ray_limit_reg) ? adapt_reg : ray_limit_reg;
        if (eff_rays < min_rays)
        begin
            eff_rays = min_rays;
        end
        clip_lo = (quo_reg < min_rays) ? min_rays : quo_reg;
    end

    assign disabled    = !(act_reg && run_reg);
    assign zero_budget = (budget_reg == '0);
    assign frac_sat    = (frac_reg > barc_pkg::FRAC_ONE) ? barc_pkg::FRAC_ONE : frac_reg;

    // one doubling of the remainder or one addition of the budget, modulo the last run time
    assign dbl      = {rem_reg, 1'b0};
    assign dbl_wrap = (dbl >= {1'b0, last_reg});
    assign add_sum  = {1'b0, rem_reg} + {1'b0, budget_reg};
    assign add_wrap = (add_sum >= {1'b0, last_reg});

    assign rounded  = RND_W'(prod_reg) + RND_ADD;
    assign step_raw = rounded[RAY_BITS+15:16];
    assign rec_sum  = {1'b0, adapt_reg} + {1'b0, step_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = '0;
            cnt_next = CNT_TOP;
        end
        else if (cmd.div_dbl)
        begin
            quo_next = {quo_reg[RAY_BITS-2:0], dbl_wrap};
            rem_next = dbl_wrap ? TIME_BITS'(dbl - {1'b0, last_reg}) : dbl[TIME_BITS-1:0];
        end
        else if (cmd.div_add)
        begin
            if (adapt_reg[cnt_reg])
            begin
                quo_next = quo_reg + RAY_BITS'(add_wrap);
                rem_next = add_wrap ? TIME_BITS'(add_sum - {1'b0, last_reg})
                                    : add_sum[TIME_BITS-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        step_next = step_raw;
        if (cap_reg != '0 && step_next > cap_reg)
        begin
            step_next = cap_reg;
        end
        if (step_next == '0)
        begin
            step_next = RAY_BITS'(1);
        end
    end

    always_comb
    begin
        adapt_next = adapt_reg;
        priority if (cmd.init)
        begin
            adapt_next = ray_limit_reg;
        end
        else if (cmd.div_commit)
        begin
            adapt_next = (clip_lo < ray_limit_reg) ? clip_lo : ray_limit_reg;
        end
        else if (cmd.recover_commit)
        begin
            adapt_next = (rec_sum < {1'b0, ray_limit_reg}) ? rec_sum[RAY_BITS-1:0]
                                                          : ray_limit_reg;
        end
    end

    always_comb
    begin
        priority if (disabled)
        begin
            out_eff_next = '0;
            out_tgt_next = '0;
        end
        else if (zero_budget)
        begin
            out_eff_next = ray_limit_reg;
            out_tgt_next = ray_limit_reg;
        end
        else
        begin
            out_eff_next = eff_rays;
            out_tgt_next = adapt_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_limit_reg <= RAY_BITS'(barc_pkg::RAY_LIMIT_RST);
            budget_reg    <= '0;
            ray_floor_reg <= RAY_BITS'(1);
            frac_reg      <= barc_pkg::FRAC_RST;
            cap_reg       <= '0;
            adapt_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    barc_pkg::CFG_RAY_LIMIT:    ray_limit_reg <= cfg_data[RAY_BITS-1:0];
                    barc_pkg::CFG_TIME_BUDGET:  budget_reg    <= cfg_data[TIME_BITS-1:0];
                    barc_pkg::CFG_RAY_FLOOR:    ray_floor_reg <= cfg_data[RAY_BITS-1:0];
                    barc_pkg::CFG_RECOVER_FRAC: frac_reg      <= cfg_data[barc_pkg::FRAC_W-1:0];
                    barc_pkg::CFG_RECOVER_CAP:  cap_reg       <= cfg_data[RAY_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            adapt_reg     <= adapt_next;
            started_reg   <= started_reg || cmd.init;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= in_active;
            run_reg  <= in_run;
            last_reg <= in_last;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(ray_limit_reg) * PROD_W'(frac_sat);
        end
        if (cmd.step)
        begin
            step_reg <= step_next;
        end
        if (cmd.load_out)
        begin
            out_eff_reg <= out_eff_next;
            out_tgt_reg <= out_tgt_next;
        end
    end

    assign status.disabled    = disabled;
    assign status.zero_budget = zero_budget;
    assign status.started     = started_reg;
    assign status.over        = (last_reg > budget_reg);
    assign status.cnt_zero    = (cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_eff   = out_eff_reg;
    assign out_tgt   = out_tgt_reg;

endmodule

[sv/budget_adaptive_ray_count_top.sv]
// Adaptive ray count controller: one request per simulation tick.
// Input stream: s_tuser carries the two enable flags, s_tdata the last run time.
// Output stream: m_tdata carries the effective ray count and the adaptive target.
// Configuration: cfg_we/cfg_addr/cfg_data write one register per clock,
// index 0 ray limit, 1 time budget, 2 ray floor, 3 recovery fraction (Q1.16),
// 4 recovery step cap. Write only while no request is in flight.
// After accept, a disabled, zero-budget or first enabled tick passes EVAL and goes
// to FINISH; a within-budget tick also passes STEP and RECOVER; an over-budget tick
// runs the bit-serial scaling divider, which handles one remainder doubling or one
// budget addition per cycle, through DIV_DONE. FINISH loads the result once the
// output register is free, and the next request is accepted in the cycle after
// the result loads.
// One request is in flight at a time; s_tready is high while the controller idles.
// A finished result sits in the output register; the next request is accepted
// meanwhile, and its result waits in the controller until m_tready frees the
// register. Stalls on m_tready never drop or repeat a result.
// Reset: configuration returns to its defaults, the adaptive target clears, the first
// enabled tick with a nonzero budget restarts it at the ray limit; no output is valid.
// Depends on barc_pkg, barc_ctrl, barc_datapath.
module budget_adaptive_ray_count_top
#(
    parameter int RAY_BITS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [barc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [((RAY_BITS > TIME_BITS) ? RAY_BITS :
                   ((TIME_BITS > barc_pkg::FRAC_W) ? TIME_BITS :
                    barc_pkg::FRAC_W))-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // last_run_us
    input  logic [((TIME_BITS + 7) / 8) * 8-1:0] s_tdata,
    // realtime_active, reflection_run
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // effective_rays, target_rays
    output logic [((2 * RAY_BITS + 7) / 8) * 8-1:0] m_tdata
);

    localparam int OUT_W = ((2 * RAY_BITS + 7) / 8) * 8;

    barc_pkg::cmd_t    cmd;
    barc_pkg::status_t status;
    logic [RAY_BITS-1:0] eff_rays;
    logic [RAY_BITS-1:0] tgt_rays;

    barc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    barc_datapath
    #(
        .RAY_BITS  (RAY_BITS),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_active (s_tuser[0]),
        .in_run    (s_tuser[1]),
        .in_last   (s_tdata[TIME_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_eff   (eff_rays),
        .out_tgt   (tgt_rays)
    );

    assign m_tdata = OUT_W'({tgt_rays, eff_rays});

endmodule
